[design/fpda_pkg.sv]
// shared constants and helpers for the fixed-point to decimal text converter
package fpda_pkg;

   localparam int DEFAULT_INT_BITS        = 16;
   localparam int DEFAULT_FRAC_BITS       = 16;
   localparam int DEFAULT_MAX_FRAC_DIGITS = 8;

   localparam int CSR_WIDTH   = 4;
   localparam int CHAR_WIDTH  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_WIDTH-1:0]  FRACTION_DIGITS_RESET = 4'd8;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO             = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_POINT            = 8'd46;

   // decimal digits needed for the largest value of a given bit width
   function automatic int int_digits(input int bits);
      longint unsigned limit;
      longint unsigned pow;
      int              n;
      limit = (64'd1 << bits) - 64'd1;
      pow   = 64'd10;
      n     = 1;
      for (int i = 0; i < 20; i++) begin
         if (pow <= limit) begin
            n   = n + 1;
            pow = pow * 64'd10;
         end
      end
      return n;
   endfunction

endpackage

[design/fpda_front.sv]
// front end: digit-count register, request acceptance and item packing
module fpda_front #(
   parameter int INT_BITS        = fpda_pkg::DEFAULT_INT_BITS,
   parameter int FRAC_BITS       = fpda_pkg::DEFAULT_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = fpda_pkg::DEFAULT_MAX_FRAC_DIGITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [INT_BITS-1:0]                       req_integer_part,
   input  logic [FRAC_BITS-1:0]                      req_fraction_part,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [fpda_pkg::CSR_WIDTH-1:0]            csr_fraction_digits,
   input  logic                                      queue_full,
   output logic                                      push,
   output logic [INT_BITS+FRAC_BITS+fpda_pkg::CSR_WIDTH-1:0] push_data
);

   localparam logic [fpda_pkg::CSR_WIDTH-1:0] MAX_DIGITS =
      fpda_pkg::CSR_WIDTH'(MAX_FRAC_DIGITS);

   logic [fpda_pkg::CSR_WIDTH-1:0] frac_digits_ff;
   logic [fpda_pkg::CSR_WIDTH-1:0] frac_digits_in;
   logic [fpda_pkg::CSR_WIDTH-1:0] digits_sat;

   assign csr_ready = 1'b1;

   always_comb begin
      frac_digits_in = frac_digits_ff;
      if (csr_valid && csr_ready) begin
         frac_digits_in = csr_fraction_digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_digits_ff <= fpda_pkg::FRACTION_DIGITS_RESET;
      end else begin
         frac_digits_ff <= frac_digits_in;
      end
   end

   // saturate the digit count to what the back end supports
   assign digits_sat = (frac_digits_ff > MAX_DIGITS) ? MAX_DIGITS : frac_digits_ff;
   assign push       = start && !queue_full;
   assign push_data  = {req_integer_part, req_fraction_part, digits_sat};

endmodule

[design/fpda_queue.sv]
// small item queue between front and back end
module fpda_queue #(
   parameter int WIDTH = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int DEPTH = fpda_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/fpda_back.sv]
// back end: binary to bcd conversion and character sequencing
module fpda_back #(
   parameter int INT_BITS        = fpda_pkg::DEFAULT_INT_BITS,
   parameter int FRAC_BITS       = fpda_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      empty,
   input  logic [INT_BITS+FRAC_BITS+fpda_pkg::CSR_WIDTH-1:0] pop_data,
   output logic                                      pop,
   output logic                                      rsp_strobe,
   output logic [fpda_pkg::CHAR_WIDTH-1:0]           rsp_char_code,
   output logic                                      rsp_last
);

   localparam int DIG   = fpda_pkg::int_digits(INT_BITS);
   localparam int IDX_W = (DIG > 1) ? $clog2(DIG) : 1;
   localparam int BIT_W = $clog2(INT_BITS);
   localparam int CW    = fpda_pkg::CSR_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CONV  = 5'b00010,
      ST_INT   = 5'b00100,
      ST_POINT = 5'b01000,
      ST_FRAC  = 5'b10000
   } back_state_type;

   back_state_type                 state_ff;
   back_state_type                 state_in;
   logic [INT_BITS-1:0]            shift_ff;
   logic [INT_BITS-1:0]            shift_in;
   logic [DIG-1:0][3:0]            bcd_ff;
   logic [DIG-1:0][3:0]            bcd_in;
   logic [DIG-1:0][3:0]            bcd_adj;
   logic [DIG-1:0][3:0]            bcd_next;
   logic [FRAC_BITS-1:0]           frac_ff;
   logic [FRAC_BITS-1:0]           frac_in;
   logic [FRAC_BITS+3:0]           frac_prod;
   logic [CW-1:0]                  nd_ff;
   logic [CW-1:0]                  nd_in;
   logic [CW-1:0]                  fcnt_ff;
   logic [CW-1:0]                  fcnt_in;
   logic [BIT_W-1:0]               bit_cnt_ff;
   logic [BIT_W-1:0]               bit_cnt_in;
   logic [IDX_W-1:0]               idx_ff;
   logic [IDX_W-1:0]               idx_in;
   logic [IDX_W-1:0]               lead_idx;
   logic                           strobe_ff;
   logic                           strobe_in;
   logic [fpda_pkg::CHAR_WIDTH-1:0] char_ff;
   logic [fpda_pkg::CHAR_WIDTH-1:0] char_in;
   logic                           last_ff;
   logic                           last_in;

   assign pop           = (state_ff == ST_IDLE) && !empty;
   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   // shift-add-3 step
   always_comb begin
      for (int i = 0; i < DIG; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      for (int i = 0; i < DIG; i++) begin
         if (i == 0) begin
            bcd_next[i] = {bcd_adj[i][2:0], shift_ff[INT_BITS-1]};
         end else begin
            bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
         end
      end
   end

   // highest nonzero digit of the finished conversion
   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < DIG; i++) begin
         if (bcd_next[i] != 4'd0) begin
            lead_idx = IDX_W'(i);
         end
      end
   end

   assign frac_prod = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);

   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      bcd_in     = bcd_ff;
      frac_in    = frac_ff;
      nd_in      = nd_ff;
      fcnt_in    = fcnt_ff;
      bit_cnt_in = bit_cnt_ff;
      idx_in     = idx_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               shift_in   = pop_data[INT_BITS+FRAC_BITS+CW-1:FRAC_BITS+CW];
               frac_in    = pop_data[FRAC_BITS+CW-1:CW];
               nd_in      = pop_data[CW-1:0];
               bcd_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = bcd_next;
            shift_in   = shift_ff << 1;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_W'(INT_BITS - 1)) begin
               idx_in   = lead_idx;
               state_in = ST_INT;
            end
         end
         ST_INT: begin
            strobe_in = 1'b1;
            char_in   = fpda_pkg::CHAR_ZERO + {4'd0, bcd_ff[idx_ff]};
            if (idx_ff == '0) begin
               last_in  = (nd_ff == '0);
               state_in = (nd_ff == '0) ? ST_IDLE : ST_POINT;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_POINT: begin
            strobe_in = 1'b1;
            char_in   = fpda_pkg::CHAR_POINT;
            fcnt_in   = '0;
            state_in  = ST_FRAC;
         end
         ST_FRAC: begin
            strobe_in = 1'b1;
            char_in   = fpda_pkg::CHAR_ZERO + {4'd0, frac_prod[FRAC_BITS+3:FRAC_BITS]};
            frac_in   = frac_prod[FRAC_BITS-1:0];
            fcnt_in   = fcnt_ff + 1'b1;
            if (fcnt_ff == nd_ff - 1'b1) begin
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      bcd_ff     <= bcd_in;
      frac_ff    <= frac_in;
      nd_ff      <= nd_in;
      fcnt_ff    <= fcnt_in;
      bit_cnt_ff <= bit_cnt_in;
      idx_ff     <= idx_in;
      char_ff    <= char_in;
   end

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      last_ff |-> strobe_ff)
      else $error("last flag without strobe");

   a_point_needs_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POINT) |-> (nd_ff != '0))
      else $error("point emitted with zero fraction digits");

   a_frac_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAC) |-> (fcnt_ff < nd_ff))
      else $error("fraction digit count overrun");

   a_no_strobe_after_idle: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_CONV) |-> !strobe_ff)
      else $error("character emitted outside an emit state");

endmodule

[design/fixed_point_to_decimal_ascii_core.sv]
// top level of the fixed-point to decimal ascii text converter
// the first character follows the start transfer through the queue and the bcd conversion
// the back end pops a new value only after the last character of the current one
// a two-entry queue takes new values while the back end still converts
// reset: synchronous, active high; clears the queue, sequencer and sets 8 fraction digits
module fixed_point_to_decimal_ascii_core #(
   parameter int INT_BITS        = fpda_pkg::DEFAULT_INT_BITS,
   parameter int FRAC_BITS       = fpda_pkg::DEFAULT_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = fpda_pkg::DEFAULT_MAX_FRAC_DIGITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [INT_BITS-1:0]              req_integer_part,
   input  logic [FRAC_BITS-1:0]             req_fraction_part,
   output logic                             rsp_strobe,
   output logic [fpda_pkg::CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fpda_pkg::CSR_WIDTH-1:0]   csr_fraction_digits
);

   localparam int ITEM_W = INT_BITS + FRAC_BITS + fpda_pkg::CSR_WIDTH;

   logic              queue_full;
   logic              queue_empty;
   logic              push;
   logic              pop;
   logic [ITEM_W-1:0] push_data;
   logic [ITEM_W-1:0] pop_data;

   assign busy = queue_full;

   fpda_front #(
      .INT_BITS        (INT_BITS),
      .FRAC_BITS       (FRAC_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_integer_part    (req_integer_part),
      .req_fraction_part   (req_fraction_part),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_fraction_digits (csr_fraction_digits),
      .queue_full          (queue_full),
      .push                (push),
      .push_data           (push_data)
   );

   fpda_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   fpda_back #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (queue_empty),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule
